>>> rtl/core/rv32_subset_execute_step_assert.svh
// ----------------------------------------------------------------------------
// RV32 subset execute step: assertion macros
// Shared concurrent assertion macros. They sample on clk_i and are disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RV32_SUBSET_EXECUTE_STEP_ASSERT_SVH
`define RV32_SUBSET_EXECUTE_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV32SE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RV32SE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rv32se_pkg.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: package
// Widths, opcodes, constants and the structs passed between the modules.
// ----------------------------------------------------------------------------
package rv32se_pkg;

  localparam int DataW       = 32;
  localparam int RegIdxW     = 5;
  localparam int RegCount    = 32;
  localparam int FuncW       = 4;
  localparam int TgtW        = 10;
  localparam int TgtMax      = 1023;
  localparam int PcOutW      = 10;
  localparam int MemAddrOutW = 12;

  // Default sizes; the data memory depth is a power of two.
  localparam int unsigned MemWordsDef  = 1024;
  localparam int unsigned ProgDepthDef = 1024;

  // An ecall exits when this register holds the exit code.
  localparam logic [RegIdxW-1:0] SysCallReg = 5'd17;
  localparam logic [DataW-1:0]   ExitCode   = 32'd10;

  typedef enum logic [FuncW-1:0] {
    FuncAdd     = 4'd0,
    FuncSub     = 4'd1,
    FuncAddi    = 4'd2,
    FuncSlli    = 4'd3,
    FuncLi      = 4'd4,
    FuncLa      = 4'd5,
    FuncLw      = 4'd6,
    FuncSw      = 4'd7,
    FuncBeq     = 4'd8,
    FuncBne     = 4'd9,
    FuncBlt     = 4'd10,
    FuncJal     = 4'd11,
    FuncJ       = 4'd12,
    FuncEcall   = 4'd13,
    FuncNop     = 4'd14,
    FuncUnknown = 4'd15
  } func_e;

  // Register file read request, issued when a beat is accepted.
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx_a;
    logic [RegIdxW-1:0] idx_b;
  } rf_rd_t;

  // Register file write, issued when a result beat leaves.
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } rf_wr_t;

  // Data memory command from the execute stage.
  typedef struct packed {
    logic wr;
    logic rd;
  } dm_cmd_t;

  // Contents of the result register.
  typedef struct packed {
    logic [PcOutW-1:0]      next_pc;
    logic                   halted;
    logic                   reg_wr;
    logic [RegIdxW-1:0]     reg_idx;
    logic [DataW-1:0]       reg_value;
    logic                   is_load;
    logic                   mem_wr;
    logic [MemAddrOutW-1:0] mem_addr;
    logic [DataW-1:0]       mem_value;
  } result_t;

endpackage

>>> rtl/core/rv32se_in_if.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: instruction channel
// Valid/ready channel that carries one decoded instruction per beat.
// ----------------------------------------------------------------------------
interface rv32se_in_if;

  logic                                valid;
  logic                                ready;
  logic [rv32se_pkg::FuncW-1:0]        func;
  logic [rv32se_pkg::RegIdxW-1:0]      dest_reg;
  logic [rv32se_pkg::RegIdxW-1:0]      src_reg_a;
  logic [rv32se_pkg::RegIdxW-1:0]      src_reg_b;
  logic signed [rv32se_pkg::DataW-1:0] immediate;
  logic [rv32se_pkg::TgtW-1:0]         branch_target;

  modport source (
    output valid, func, dest_reg, src_reg_a, src_reg_b, immediate, branch_target,
    input  ready
  );

  modport sink (
    input  valid, func, dest_reg, src_reg_a, src_reg_b, immediate, branch_target,
    output ready
  );

endinterface

>>> rtl/core/rv32se_out_if.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: result channel
// Valid/ready channel that carries one execution result per beat.
// ----------------------------------------------------------------------------
interface rv32se_out_if;

  logic                                  valid;
  logic                                  ready;
  logic [rv32se_pkg::PcOutW-1:0]         next_pc;
  logic                                  halted;
  logic                                  reg_written;
  logic [rv32se_pkg::RegIdxW-1:0]        reg_index;
  logic signed [rv32se_pkg::DataW-1:0]   reg_value;
  logic                                  mem_written;
  logic [rv32se_pkg::MemAddrOutW-1:0]    mem_address;
  logic signed [rv32se_pkg::DataW-1:0]   mem_value;

  modport source (
    output valid, next_pc, halted, reg_written, reg_index, reg_value,
           mem_written, mem_address, mem_value,
    input  ready
  );

  modport sink (
    input  valid, next_pc, halted, reg_written, reg_index, reg_value,
           mem_written, mem_address, mem_value,
    output ready
  );

endinterface

>>> rtl/core/rv32_subset_execute_step.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: top level
// Executes one decoded instruction per beat and reports its effects.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one decoded instruction per beat; out_o returns exactly one
//   result beat per instruction, in order. Both use valid/ready.
//   An accepted instruction beat is captured in the read stage while the
//   register file is read, then executes into the result register when
//   the read stage advances. Throughput: one instruction per cycle, when
//   out_o.ready is high and the memory clear is done, including loads and
//   dependent instructions; operands are forwarded from the result register.
//   The path that sets the cycle time runs from the data memory read
//   register through the forwarding mux and the address adder.
//   Reset clears the pc, the halt flag and the register file at once; the
//   data memory is then swept to zero while in_i.ready is held low.
//   MEM_WORDS must be a power of two; the block itself does not enforce it.
//   When out_o.ready is low the result holds, the instruction behind it
//   waits in the read stage, and in_i.ready drops once both are full.
// ----------------------------------------------------------------------------
`include "rv32_subset_execute_step_assert.svh"

module rv32_subset_execute_step #(
  parameter int unsigned MEM_WORDS  = rv32se_pkg::MemWordsDef,
  parameter int unsigned PROG_DEPTH = rv32se_pkg::ProgDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rv32se_in_if.sink    in_i,
  rv32se_out_if.source out_o
);

  localparam int unsigned PcW   = $clog2(PROG_DEPTH);
  localparam int unsigned MemAw = $clog2(MEM_WORDS);
  localparam int TgtQb = $clog2(rv32se_pkg::TgtMax / PROG_DEPTH + 1);

  // Handshakes.
  logic in_acc;
  logic s1_adv;
  logic out_acc;

  // Read stage.
  logic                               s1_valid_q;
  rv32se_pkg::func_e                  s1_func_q;
  logic [rv32se_pkg::RegIdxW-1:0]     s1_rd_q;
  logic [rv32se_pkg::RegIdxW-1:0]     s1_ra_q;
  logic [rv32se_pkg::RegIdxW-1:0]     s1_rb_q;
  logic [rv32se_pkg::DataW-1:0]       s1_imm_q;
  logic [PcW-1:0]                     s1_tgt_q;
  logic [rv32se_pkg::TgtW-1:0]        tgt_rem;
  logic [PcW+rv32se_pkg::TgtW-1:0]    tgt_ext;

  // Architectural pc and halt flag.
  logic [PcW-1:0] pc_q;
  logic           halt_q;

  // Result stage.
  logic                s2_valid_q;
  rv32se_pkg::result_t s2_q;
  rv32se_pkg::result_t s2_d;
  logic [rv32se_pkg::DataW-1:0] s2_wval;

  // Execute.
  logic [rv32se_pkg::DataW-1:0] rf_a;
  logic [rv32se_pkg::DataW-1:0] rf_b;
  logic [rv32se_pkg::DataW-1:0] rf_sys;
  logic [rv32se_pkg::DataW-1:0] op_a;
  logic [rv32se_pkg::DataW-1:0] op_b;
  logic [rv32se_pkg::DataW-1:0] op_sys;
  logic [rv32se_pkg::DataW-1:0] mem_byte;
  logic [rv32se_pkg::DataW-1:0] ex_wval;
  logic [PcW-1:0]               pc_inc;
  logic [PcW-1:0]               ex_next;
  logic                         ex_halted;
  logic                         ex_wr;
  logic                         ex_ld;
  logic                         ex_mw;
  logic [PcW+rv32se_pkg::PcOutW-1:0]           pc_ext;
  logic [MemAw+2+rv32se_pkg::MemAddrOutW-1:0]  addr_ext;

  // Memories.
  rv32se_pkg::rf_rd_t           rf_rd;
  rv32se_pkg::rf_wr_t           rf_wr;
  rv32se_pkg::dm_cmd_t          dm_cmd;
  logic [MemAw-1:0]             dm_addr;
  logic [rv32se_pkg::DataW-1:0] dm_rdata;
  logic                         dm_busy;

  // Flow control: the read stage moves on when the result register frees.
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready = !dm_busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = s2_valid_q && out_o.ready;

  // Reduce the branch target modulo the program depth by restoring steps.
  always_comb begin
    tgt_rem = in_i.branch_target;
    for (int k = TgtQb - 1; k >= 0; k--) begin
      if (32'(tgt_rem) >= (32'(PROG_DEPTH) << k)) begin
        tgt_rem = tgt_rem - rv32se_pkg::TgtW'(32'(PROG_DEPTH) << k);
      end
    end
    tgt_ext = {{PcW{1'b0}}, tgt_rem};
  end

  // Read stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= rv32se_pkg::func_e'(in_i.func);
      s1_rd_q   <= in_i.dest_reg;
      s1_ra_q   <= in_i.src_reg_a;
      s1_rb_q   <= in_i.src_reg_b;
      s1_imm_q  <= in_i.immediate;
      s1_tgt_q  <= tgt_ext[PcW-1:0];
    end
  end

  // Register file; banks are read as the beat is accepted.
  assign rf_rd.en    = in_acc;
  assign rf_rd.idx_a = in_i.src_reg_a;
  assign rf_rd.idx_b = in_i.src_reg_b;

  assign rf_wr.en   = out_acc && s2_q.reg_wr;
  assign rf_wr.idx  = s2_q.reg_idx;
  assign rf_wr.data = s2_wval;

  rv32se_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rf_rd),
    .lk_idx_a_i (s1_ra_q),
    .lk_idx_b_i (s1_rb_q),
    .wr_i       (rf_wr),
    .data_a_o   (rf_a),
    .data_b_o   (rf_b),
    .sys_data_o (rf_sys)
  );

  // Value the result register will write; loads take it from the memory.
  assign s2_wval = s2_q.is_load ? dm_rdata : s2_q.reg_value;

  // Forward the pending write of the result register to the operands.
  always_comb begin
    op_a   = rf_a;
    op_b   = rf_b;
    op_sys = rf_sys;
    if (s2_valid_q && s2_q.reg_wr) begin
      if (s2_q.reg_idx == s1_ra_q) begin
        op_a = s2_wval;
      end
      if (s2_q.reg_idx == s1_rb_q) begin
        op_b = s2_wval;
      end
      if (s2_q.reg_idx == rv32se_pkg::SysCallReg) begin
        op_sys = s2_wval;
      end
    end
  end

  // Execute the instruction in the read stage.
  always_comb begin
    pc_inc    = (pc_q == PcW'(PROG_DEPTH - 1)) ? '0 : pc_q + 1'b1;
    mem_byte  = op_a + s1_imm_q;
    ex_next   = pc_inc;
    ex_halted = halt_q;
    ex_wr     = 1'b0;
    ex_ld     = 1'b0;
    ex_mw     = 1'b0;
    ex_wval   = '0;
    if (halt_q) begin
      ex_next = pc_q;
    end else begin
      case (s1_func_q)
        rv32se_pkg::FuncAdd: begin
          ex_wr   = 1'b1;
          ex_wval = op_a + op_b;
        end
        rv32se_pkg::FuncSub: begin
          ex_wr   = 1'b1;
          ex_wval = op_a - op_b;
        end
        rv32se_pkg::FuncAddi: begin
          ex_wr   = 1'b1;
          ex_wval = mem_byte;
        end
        rv32se_pkg::FuncSlli: begin
          ex_wr   = 1'b1;
          ex_wval = op_a << s1_imm_q[4:0];
        end
        rv32se_pkg::FuncLi, rv32se_pkg::FuncLa: begin
          ex_wr   = 1'b1;
          ex_wval = s1_imm_q;
        end
        rv32se_pkg::FuncLw: begin
          ex_wr = 1'b1;
          ex_ld = 1'b1;
        end
        rv32se_pkg::FuncSw: begin
          ex_mw = 1'b1;
        end
        rv32se_pkg::FuncBeq: begin
          if (op_a == op_b) begin
            ex_next = s1_tgt_q;
          end
        end
        rv32se_pkg::FuncBne: begin
          if (op_a != op_b) begin
            ex_next = s1_tgt_q;
          end
        end
        rv32se_pkg::FuncBlt: begin
          if ($signed(op_a) < $signed(op_b)) begin
            ex_next = s1_tgt_q;
          end
        end
        rv32se_pkg::FuncJal, rv32se_pkg::FuncJ: begin
          ex_next = s1_tgt_q;
        end
        rv32se_pkg::FuncEcall: begin
          if (op_sys == rv32se_pkg::ExitCode) begin
            ex_halted = 1'b1;
            ex_next   = pc_q;
          end
        end
        rv32se_pkg::FuncNop: begin
          ex_halted = 1'b1;
          ex_next   = pc_q;
        end
        default: begin
        end
      endcase
      // Writes to x0 are dropped.
      if (s1_rd_q == '0) begin
        ex_wr   = 1'b0;
        ex_ld   = 1'b0;
        ex_wval = '0;
      end
    end
  end

  // Build the result register contents.
  always_comb begin
    pc_ext           = {{rv32se_pkg::PcOutW{1'b0}}, ex_next};
    addr_ext         = {{rv32se_pkg::MemAddrOutW{1'b0}}, mem_byte[MemAw+1:0]};
    s2_d.next_pc     = pc_ext[rv32se_pkg::PcOutW-1:0];
    s2_d.halted      = ex_halted;
    s2_d.reg_wr      = ex_wr;
    s2_d.reg_idx     = ex_wr ? s1_rd_q : '0;
    s2_d.reg_value   = ex_wval;
    s2_d.is_load     = ex_ld;
    s2_d.mem_wr      = ex_mw;
    s2_d.mem_addr    = ex_mw ? addr_ext[rv32se_pkg::MemAddrOutW-1:0] : '0;
    s2_d.mem_value   = ex_mw ? op_b : '0;
  end

  // Data memory access as the instruction leaves the read stage.
  assign dm_cmd.rd = s1_adv && ex_ld;
  assign dm_cmd.wr = s1_adv && ex_mw;
  assign dm_addr   = mem_byte[MemAw+1:2];

  rv32se_dmem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (dm_cmd),
    .addr_i  (dm_addr),
    .wdata_i (op_b),
    .rdata_o (dm_rdata),
    .busy_o  (dm_busy)
  );

  // Architectural state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      halt_q     <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        pc_q   <= ex_next;
        halt_q <= ex_halted;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_acc) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= s2_d;
    end
  end

  // Result beat.
  assign out_o.valid       = s2_valid_q;
  assign out_o.next_pc     = s2_q.next_pc;
  assign out_o.halted      = s2_q.halted;
  assign out_o.reg_written = s2_q.reg_wr;
  assign out_o.reg_index   = s2_q.reg_idx;
  assign out_o.reg_value   = s2_wval;
  assign out_o.mem_written = s2_q.mem_wr;
  assign out_o.mem_address = s2_q.mem_addr;
  assign out_o.mem_value   = s2_q.mem_value;

  // Checks.
  `RV32SE_ASSERT_IMP(a_no_x0_write, s2_valid_q && s2_q.reg_wr, s2_q.reg_idx != '0, "x0 written")
  `RV32SE_ASSERT_IMP(a_halt_quiet, s2_valid_q && s2_q.halted, !s2_q.reg_wr && !s2_q.mem_wr, "write while halted")
  `RV32SE_ASSERT_NXT(a_halt_sticky, halt_q, halt_q && $stable(pc_q), "halt released or pc moved")
  `RV32SE_ASSERT_IMP(a_no_accept_clear, in_acc, !dm_busy, "beat accepted during memory clear")
  `RV32SE_ASSERT_IMP(a_ld_st_excl, s2_valid_q, !(s2_q.is_load && s2_q.mem_wr), "load and store together")

endmodule

>>> rtl/core/rv32se_ram.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: generic RAM
// One write port and one read port with registered read data. A read in
// the same cycle as a write to the same entry returns the old contents.
// ----------------------------------------------------------------------------
module rv32se_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rv32se_regfile.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: register file
// Two RAM banks give two read ports. Per-entry valid bits make unwritten
// registers read zero after reset, and a last-write register covers a write
// that lands in the same cycle as the bank read. x17 has a shadow copy.
// ----------------------------------------------------------------------------
module rv32se_regfile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rv32se_pkg::rf_rd_t                  rd_i,
  input  logic [rv32se_pkg::RegIdxW-1:0]      lk_idx_a_i,
  input  logic [rv32se_pkg::RegIdxW-1:0]      lk_idx_b_i,
  input  rv32se_pkg::rf_wr_t                  wr_i,
  output logic [rv32se_pkg::DataW-1:0]        data_a_o,
  output logic [rv32se_pkg::DataW-1:0]        data_b_o,
  output logic [rv32se_pkg::DataW-1:0]        sys_data_o
);

  logic [rv32se_pkg::RegCount-1:0] valid_q;
  logic                            last_vld_q;
  logic [rv32se_pkg::RegIdxW-1:0]  last_idx_q;
  logic [rv32se_pkg::DataW-1:0]    last_data_q;
  logic [rv32se_pkg::DataW-1:0]    sys_q;
  logic [rv32se_pkg::DataW-1:0]    bank_a;
  logic [rv32se_pkg::DataW-1:0]    bank_b;

  // Both banks take every write; each serves one read port.
  rv32se_ram #(
    .WIDTH(rv32se_pkg::DataW),
    .DEPTH(rv32se_pkg::RegCount)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.data),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.idx_a),
    .rdata_o (bank_a)
  );

  rv32se_ram #(
    .WIDTH(rv32se_pkg::DataW),
    .DEPTH(rv32se_pkg::RegCount)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.data),
    .re_i    (rd_i.en),
    .raddr_i (rd_i.idx_b),
    .rdata_o (bank_b)
  );

  // Valid bits, last-write tracking and the x17 shadow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      last_vld_q <= 1'b0;
      sys_q      <= '0;
    end else if (wr_i.en && (wr_i.idx != '0)) begin
      valid_q[wr_i.idx] <= 1'b1;
      last_vld_q        <= 1'b1;
      if (wr_i.idx == rv32se_pkg::SysCallReg) begin
        sys_q <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      last_idx_q  <= wr_i.idx;
      last_data_q <= wr_i.data;
    end
  end

  // Committed register values; x0 and never-written entries read zero.
  always_comb begin
    data_a_o = '0;
    data_b_o = '0;
    if (lk_idx_a_i != '0) begin
      if (last_vld_q && (last_idx_q == lk_idx_a_i)) begin
        data_a_o = last_data_q;
      end else if (valid_q[lk_idx_a_i]) begin
        data_a_o = bank_a;
      end
    end
    if (lk_idx_b_i != '0) begin
      if (last_vld_q && (last_idx_q == lk_idx_b_i)) begin
        data_b_o = last_data_q;
      end else if (valid_q[lk_idx_b_i]) begin
        data_b_o = bank_b;
      end
    end
  end

  assign sys_data_o = sys_q;

endmodule

>>> rtl/core/rv32se_dmem.sv
// ----------------------------------------------------------------------------
// RV32 subset execute step: data memory
// Word-addressed RAM with a clearing sweep after reset that zeroes one word
// per cycle. The memory reports busy until the sweep is done.
// ----------------------------------------------------------------------------
module rv32se_dmem #(
  parameter int unsigned MEM_WORDS = rv32se_pkg::MemWordsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rv32se_pkg::dm_cmd_t           cmd_i,
  input  logic [$clog2(MEM_WORDS)-1:0]  addr_i,
  input  logic [rv32se_pkg::DataW-1:0]  wdata_i,
  output logic [rv32se_pkg::DataW-1:0]  rdata_o,
  output logic                          busy_o
);

  localparam int unsigned AddrW = $clog2(MEM_WORDS);

  logic             busy_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [rv32se_pkg::DataW-1:0] ram_wdata;

  // Clearing sweep over every word after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(MEM_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The sweep owns the write port while it runs.
  always_comb begin
    ram_we    = busy_q | cmd_i.wr;
    ram_waddr = busy_q ? clr_cnt_q : addr_i;
    ram_wdata = busy_q ? '0 : wdata_i;
  end

  rv32se_ram #(
    .WIDTH(rv32se_pkg::DataW),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd & ~busy_q),
    .raddr_i (addr_i),
    .rdata_o (rdata_o)
  );

  assign busy_o = busy_q;

endmodule
